// File: hw/rtl/lzss_pkg.sv
// ----------------------------------------------------------------------------
// lzss_pkg
// shared types and constants for the lzss stream decompressor
// ----------------------------------------------------------------------------
package lzss_pkg;

  localparam int unsigned HIST_DEPTH = 4096;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
  localparam int unsigned NIB_W      = 4;
  localparam int unsigned DIST_SHIFT = 4;
  localparam int unsigned DIST_W     = 8 + DIST_SHIFT;
  localparam logic [31:0] ID_WORD    = 32'h5353_5a4c;

  typedef logic [7:0]         byte_t;
  typedef logic [HIST_AW-1:0] haddr_t;

  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_OK   = 2'd1,
    ST_ERR  = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_LIT   = 2'd1,
    CMD_MATCH = 2'd2,
    CMD_STAT  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    byte_t              data;
    logic [DIST_W-1:0]  distance;
    logic [NIB_W-1:0]   nib;
    stat_t              status;
  } cmd_t;

  typedef struct packed {
    byte_t  data;
    stat_t  status;
    logic   last;
  } res_t;

endpackage

// File: hw/rtl/lzss_parse.sv
// ----------------------------------------------------------------------------
// lzss_parse
// header check, flag decode and command issue for the copy engine
// ----------------------------------------------------------------------------
module lzss_parse (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           beat,
  input  lzss_pkg::byte_t in_byte,
  input  logic           final_req,
  output lzss_pkg::cmd_t cmd
);
  import lzss_pkg::*;

  typedef enum logic [6:0] {
    PH_HEADER   = 7'b0000001,
    PH_FLAG     = 7'b0000010,
    PH_LITERAL  = 7'b0000100,
    PH_MATCH_HI = 7'b0001000,
    PH_MATCH_LO = 7'b0010000,
    PH_DONE     = 7'b0100000,
    PH_ERROR    = 7'b1000000
  } phase_t;

  phase_t       phase_r, phase_nxt;
  logic [2:0]   hidx_r, hidx_nxt;
  logic [31:0]  exp_r, exp_nxt;
  logic [31:0]  count_r, count_nxt;
  logic         ovf_r, ovf_nxt;
  byte_t        flag_r, flag_nxt;
  logic [2:0]   fphase_r, fphase_nxt;
  byte_t        dhi_r, dhi_nxt;

  logic [4:0]        len;
  logic [32:0]       sum;
  byte_t             want;
  byte_t             fshift;
  logic [2:0]        fphase_inc;
  logic [DIST_W-1:0] distance;

  assign want       = ID_WORD[{hidx_r[1:0], 3'b000} +: 8];
  assign distance   = {dhi_r, in_byte[7:DIST_SHIFT]};
  assign fshift     = {1'b0, flag_r[7:1]};
  assign fphase_inc = fphase_r + 3'd1;
  assign len        = (phase_r == PH_LITERAL) ? 5'd1 : {1'b0, in_byte[NIB_W-1:0]} + 5'd1;
  assign sum        = {1'b0, count_r} + {28'd0, len};

  always_comb begin
    phase_nxt     = phase_r;
    hidx_nxt      = hidx_r;
    exp_nxt       = exp_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    flag_nxt      = flag_r;
    fphase_nxt    = fphase_r;
    dhi_nxt       = dhi_r;
    cmd.kind      = CMD_NONE;
    cmd.data      = in_byte;
    cmd.distance  = distance;
    cmd.nib       = in_byte[NIB_W-1:0];
    cmd.status    = ST_ERR;
    if (beat) begin
      unique case (phase_r) inside
        PH_HEADER: begin
          if (final_req || (!hidx_r[2] && in_byte != want)) begin
            phase_nxt = PH_ERROR;
            cmd.kind  = CMD_STAT;
          end else begin
            if (hidx_r[2]) begin
              exp_nxt[{hidx_r[1:0], 3'b000} +: 8] = in_byte;
            end
            hidx_nxt = hidx_r + 3'd1;
            if (hidx_r == 3'd7) begin
              if (exp_nxt == 32'd0) begin
                phase_nxt = PH_ERROR;
                cmd.kind  = CMD_STAT;
              end else begin
                phase_nxt  = PH_FLAG;
                fphase_nxt = 3'd0;
              end
            end
          end
        end
        PH_FLAG: begin
          if (final_req) begin
            phase_nxt = PH_ERROR;
            cmd.kind  = CMD_STAT;
          end else begin
            flag_nxt  = in_byte;
            phase_nxt = in_byte[0] ? PH_MATCH_HI : PH_LITERAL;
          end
        end
        PH_MATCH_HI: begin
          if (final_req) begin
            phase_nxt = PH_ERROR;
            cmd.kind  = CMD_STAT;
          end else begin
            dhi_nxt   = in_byte;
            phase_nxt = PH_MATCH_LO;
          end
        end
        PH_LITERAL, PH_MATCH_LO: begin
          if (phase_r == PH_MATCH_LO && in_byte[NIB_W-1:0] == '0) begin
            cmd.kind = CMD_STAT;
            if (!ovf_r && count_r == exp_r) begin
              phase_nxt  = PH_DONE;
              cmd.status = ST_OK;
            end else begin
              phase_nxt = PH_ERROR;
            end
          end else if (final_req ||
                       (phase_r == PH_MATCH_LO && !ovf_r && {20'd0, distance} >= count_r)) begin
            phase_nxt = PH_ERROR;
            cmd.kind  = CMD_STAT;
          end else begin
            cmd.kind = (phase_r == PH_LITERAL) ? CMD_LIT : CMD_MATCH;
            if (sum[32]) begin
              count_nxt = '1;
              ovf_nxt   = 1'b1;
            end else begin
              count_nxt = sum[31:0];
            end
            flag_nxt   = fshift;
            fphase_nxt = fphase_inc;
            if (fphase_inc == 3'd0) begin
              phase_nxt = PH_FLAG;
            end else begin
              phase_nxt = fshift[0] ? PH_MATCH_HI : PH_LITERAL;
            end
          end
        end
        PH_DONE, PH_ERROR: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      hidx_r   <= '0;
      exp_r    <= '0;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      flag_r   <= '0;
      fphase_r <= '0;
      dhi_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      hidx_r   <= hidx_nxt;
      exp_r    <= exp_nxt;
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      flag_r   <= flag_nxt;
      fphase_r <= fphase_nxt;
      dhi_r    <= dhi_nxt;
    end
  end

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |=> phase_r == PH_DONE)
    else $error("left done state");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERROR |=> phase_r == PH_ERROR)
    else $error("left error state");

  a_no_cmd_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE || phase_r == PH_ERROR) |-> cmd.kind == CMD_NONE)
    else $error("command after end of stream");

endmodule

// File: hw/rtl/lzss_copy_eng.sv
// ----------------------------------------------------------------------------
// lzss_copy_eng
// history memory with literal writes and match copies, one byte per cycle while the output is free
// ----------------------------------------------------------------------------
module lzss_copy_eng (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_vld,
  input  lzss_pkg::cmd_t cmd,
  output logic           cmd_ready,
  input  logic           out_free,
  output logic           emit_vld,
  output lzss_pkg::res_t emit
);
  import lzss_pkg::*;

  byte_t  mem [HIST_DEPTH];
  byte_t  mem_q_r;

  logic             rd_act_r;
  logic [NIB_W-1:0] rd_cnt_r;
  haddr_t           rd_addr_r;
  haddr_t           wp_r, wp_nxt;

  logic   s1_vld_r;
  logic   s1_ram_r;
  byte_t  s1_byte_r;
  stat_t  s1_stat_r;
  logic   s1_last_r;
  logic   fwd_hit_r;
  byte_t  fwd_byte_r;

  logic   s1_adv;
  logic   rd_en;
  logic   wr_en;
  byte_t  s1_data;
  logic   take_cmd;

  assign s1_data   = s1_ram_r ? (fwd_hit_r ? fwd_byte_r : mem_q_r) : s1_byte_r;
  assign s1_adv    = s1_vld_r && out_free;
  assign cmd_ready = !rd_act_r && (!s1_vld_r || s1_adv);
  assign rd_en     = rd_act_r && (!s1_vld_r || s1_adv);
  assign wr_en     = s1_adv && (s1_stat_r == ST_DATA);
  assign wp_nxt    = wp_r + {{(HIST_AW-1){1'b0}}, wr_en};
  assign take_cmd  = cmd_vld && cmd_ready;

  assign emit_vld    = s1_vld_r;
  assign emit.data   = s1_data;
  assign emit.status = s1_stat_r;
  assign emit.last   = s1_last_r;

  // history memory, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= s1_data;
    end
    if (rd_en) begin
      mem_q_r    <= mem[rd_addr_r];
      fwd_hit_r  <= wr_en && (wp_r == rd_addr_r);
      fwd_byte_r <= s1_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_act_r <= 1'b0;
      wp_r     <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      wp_r <= wp_nxt;
      if (rd_en) begin
        rd_act_r <= (rd_cnt_r != '0);
      end else if (take_cmd && cmd.kind == CMD_MATCH) begin
        rd_act_r <= 1'b1;
      end
      if (rd_en || (take_cmd && (cmd.kind == CMD_LIT || cmd.kind == CMD_STAT))) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_cnt_r  <= rd_cnt_r - {{(NIB_W-1){1'b0}}, 1'b1};
      rd_addr_r <= rd_addr_r + {{(HIST_AW-1){1'b0}}, 1'b1};
      s1_ram_r  <= 1'b1;
      s1_stat_r <= ST_DATA;
      s1_last_r <= (rd_cnt_r == '0);
    end else if (take_cmd) begin
      case (cmd.kind)
        CMD_MATCH: begin
          rd_cnt_r  <= cmd.nib;
          rd_addr_r <= wp_nxt - cmd.distance[HIST_AW-1:0] - {{(HIST_AW-1){1'b0}}, 1'b1};
        end
        CMD_LIT: begin
          s1_ram_r  <= 1'b0;
          s1_byte_r <= cmd.data;
          s1_stat_r <= ST_DATA;
          s1_last_r <= 1'b1;
        end
        CMD_STAT: begin
          s1_ram_r  <= 1'b0;
          s1_byte_r <= '0;
          s1_stat_r <= cmd.status;
          s1_last_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  a_hold_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !out_free) |-> !rd_en)
    else $error("read issued while stage held");

  a_copy_blocks_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    rd_act_r |-> !cmd_ready)
    else $error("command taken during copy");

  a_stat_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s1_stat_r != ST_DATA) |-> !rd_act_r)
    else $error("status result during copy");

  a_last_ends_copy: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && rd_cnt_r == '0) |=> !rd_act_r)
    else $error("copy ran past its length");

endmodule

// File: hw/rtl/lzss_stream_decompressor.sv
// ----------------------------------------------------------------------------
// lzss_stream_decompressor
// lzss decoder with 4 KiB history and header, distance and size checks
// ----------------------------------------------------------------------------
// Takes one compressed byte per beat. A literal leaves one output beat. A match
// of L bytes is read from the history RAM, which has a single read port and
// returns one byte per cycle while the output is free, with a forward of the
// byte written in the same cycle so overlapping copies work. A stalled output
// holds the copy in place, and no input byte is taken while a copy runs.
// Output tuser carries 0 data, 1 stream finished ok, 2 error; tlast marks the
// final beat produced by one input byte. After ok or error, input is drained
// and ignored until reset.
module lzss_stream_decompressor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [1:0] status
  output logic       out_tlast
);
  import lzss_pkg::*;

  cmd_t  cmd;
  res_t  emit;
  logic  emit_vld;
  logic  cmd_ready;
  logic  beat;
  logic  out_free;

  logic  out_vld_r;
  res_t  out_r;

  assign beat      = in_tvalid && in_tready;
  assign in_tready = cmd_ready;
  assign out_free  = !out_vld_r || out_tready;

  lzss_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (beat),
    .in_byte   (in_tdata),
    .final_req (in_tlast),
    .cmd       (cmd)
  );

  lzss_copy_eng u_copy (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_vld   (beat),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .out_free  (out_free),
    .emit_vld  (emit_vld),
    .emit      (emit)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= emit_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit_vld) begin
      out_r <= emit;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r.data;
  assign out_tuser  = out_r.status;
  assign out_tlast  = out_r.last;

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for lzss_stream_decompressor
// ----------------------------------------------------------------------------
// A single compressed stream is built in memory. It has a header, a directed
// opening, a long body of random literals and copies, and one ending drawn at
// random: a clean finish, a size mismatch, a bad distance or an early final
// byte. A few seeds break the header instead. The stream is then sent beat by
// beat, with random gaps on the input side and random stalls on the output
// side, followed by a tail of bytes that must be ignored. A decoder model runs
// on every accepted input beat and queues the beats it expects. Each output
// beat is checked against the oldest of those.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lzss_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER, PH_FLAG, PH_LIT, PH_COPY_HI, PH_COPY_LO, PH_DONE, PH_ERR
  } phase_t;

  typedef enum logic [2:0] {
    END_OK, END_OK_FIN, END_SIZE_LOW, END_SIZE_HIGH, END_BAD_DIST, END_EARLY
  } end_kind_t;

  typedef enum logic [1:0] {
    HDR_GOOD, HDR_BAD_ID, HDR_EARLY, HDR_ZERO_SIZE
  } hdr_kind_t;

  typedef struct packed {
    logic  is_copy;
    byte_t b0;
    byte_t b1;
  } plan_cmd_t;

  typedef struct packed {
    byte_t data;
    logic  fin;
  } plan_beat_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  // decoder model state
  byte_t       hist [HIST_DEPTH];
  haddr_t      wr_ptr    = '0;
  logic [31:0] out_count = '0;
  logic [31:0] size_want = '0;
  logic [3:0]  hdr_idx   = '0;
  byte_t       flags     = '0;
  logic [2:0]  cmd_idx   = '0;
  phase_t      phase     = PH_HEADER;
  byte_t       dist_hi   = '0;
  logic        count_sat = 1'b0;
  res_t        exp_q [$];
  res_t        want_res;

  // stream under construction
  plan_cmd_t   cmd_q [$];
  plan_beat_t  body_q [$];
  plan_beat_t  stream_q [$];
  logic [31:0] plan_len  = '0;
  int unsigned cmd_bytes = 0;
  logic [31:0] size_field;
  end_kind_t   ending;
  hdr_kind_t   hdr_kind;

  bit          calm       = 1'b0;
  int unsigned stall_left = 0;
  int unsigned n_in       = 0;
  int unsigned n_out      = 0;
  int unsigned n_err      = 0;

  lzss_stream_decompressor u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    n_err++;
    if (n_err <= 30) begin
      $display("mismatch %0s: got %0h want %0h (out beat %0d, t=%0t)",
               what, got, want, n_out, $realtime);
    end
  endtask

  function automatic void expect_res(byte_t d, stat_t s, logic l);
    res_t r;
    r.data   = d;
    r.status = s;
    r.last   = l;
    exp_q = {exp_q, r};
  endfunction

  function automatic void stream_error();
    phase = PH_ERR;
    expect_res(8'h00, ST_ERR, 1'b1);
  endfunction

  function automatic void store_out(byte_t v);
    hist[wr_ptr] = v;
    wr_ptr++;
    if (out_count == 32'hFFFF_FFFF) count_sat = 1'b1;
    else out_count++;
  endfunction

  function automatic void next_cmd();
    flags = flags >> 1;
    cmd_idx++;
    if (cmd_idx == 3'd0) phase = PH_FLAG;
    else if (flags[0]) phase = PH_COPY_HI;
    else phase = PH_LIT;
  endfunction

  function automatic void decode_beat(byte_t b, logic fin);
    logic [DIST_W-1:0] distance;
    haddr_t            src;
    byte_t             v;
    int unsigned       len;
    case (phase)
      PH_HEADER: begin
        if (fin || (hdr_idx < 4 && b != ID_WORD[8*hdr_idx +: 8])) begin
          stream_error();
        end else begin
          if (hdr_idx >= 4) size_want[8*(hdr_idx-4) +: 8] = b;
          hdr_idx++;
          if (hdr_idx == 4'd8) begin
            if (size_want == 0) begin
              stream_error();
            end else begin
              cmd_idx = '0;
              phase   = PH_FLAG;
            end
          end
        end
      end
      PH_FLAG: begin
        if (fin) begin
          stream_error();
        end else begin
          flags = b;
          phase = b[0] ? PH_COPY_HI : PH_LIT;
        end
      end
      PH_LIT: begin
        if (fin) begin
          stream_error();
        end else begin
          store_out(b);
          expect_res(b, ST_DATA, 1'b1);
          next_cmd();
        end
      end
      PH_COPY_HI: begin
        if (fin) begin
          stream_error();
        end else begin
          dist_hi = b;
          phase   = PH_COPY_LO;
        end
      end
      PH_COPY_LO: begin
        distance = {dist_hi, b[7:4]};
        len      = b[3:0] + 1;
        if (b[3:0] == 4'd0) begin
          if (!count_sat && out_count == size_want) begin
            phase = PH_DONE;
            expect_res(8'h00, ST_OK, 1'b1);
          end else begin
            stream_error();
          end
        end else if (fin || (!count_sat && distance >= out_count)) begin
          stream_error();
        end else begin
          for (int unsigned i = 0; i < len; i++) begin
            src = wr_ptr - haddr_t'(distance) - haddr_t'(1);
            v   = hist[src];
            store_out(v);
            expect_res(v, ST_DATA, i == len - 1);
          end
          next_cmd();
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        n_in++;
        decode_beat(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        n_out++;
        if (exp_q.size() == 0) begin
          report_mismatch("beat with nothing expected", out_tdata, 0);
        end else begin
          want_res = exp_q.pop_front();
          if (out_tdata !== want_res.data)
            report_mismatch("out_byte", out_tdata, want_res.data);
          if (out_tuser !== want_res.status)
            report_mismatch("status", out_tuser, want_res.status);
          if (out_tlast !== want_res.last)
            report_mismatch("last", out_tlast, want_res.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 17);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_beat(input byte_t b, input logic fin);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do begin
      @(posedge clk);
    end while (!in_tready);
  endtask

  task automatic add_literal(byte_t v);
    cmd_q = {cmd_q, plan_cmd_t'({1'b0, v, 8'h00})};
    plan_len++;
    cmd_bytes++;
  endtask

  task automatic add_copy(int unsigned distance, int unsigned nib);
    cmd_q = {cmd_q, plan_cmd_t'({1'b1, distance[11:4], distance[3:0], nib[3:0]})};
    if (nib[3:0] != 0) plan_len += nib[3:0] + 1;
    cmd_bytes += 2;
  endtask

  task automatic pack_commands();
    byte_t flag;
    for (int g = 0; g < cmd_q.size(); g += 8) begin
      flag = byte_t'($urandom);
      for (int k = 0; k < 8 && g + k < cmd_q.size(); k++) flag[k] = cmd_q[g+k].is_copy;
      body_q = {body_q, plan_beat_t'({flag, 1'b0})};
      for (int k = 0; k < 8 && g + k < cmd_q.size(); k++) begin
        body_q = {body_q, plan_beat_t'({cmd_q[g+k].b0, 1'b0})};
        if (cmd_q[g+k].is_copy) body_q = {body_q, plan_beat_t'({cmd_q[g+k].b1, 1'b0})};
      end
    end
  endtask

  task automatic test_directed_commands();
    add_literal(8'h00);
    add_literal(8'hFF);
    add_literal(8'h55);
    add_literal(8'hAA);
    add_copy(0, 1);
    add_copy(3, 15);
    add_copy(plan_len - 1, 15);
    add_copy(0, 15);
    add_literal(8'h80);
  endtask

  task automatic test_random_commands();
    int unsigned lim, d, r;
    while (cmd_bytes + (cmd_q.size() + 7) / 8 < 430) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        add_literal(r < 4 ? 8'hFF : (r < 8 ? 8'h00 : byte_t'($urandom)));
      end else begin
        lim = plan_len > HIST_DEPTH ? HIST_DEPTH : plan_len;
        r = $urandom_range(0, 9);
        if (r < 5) d = $urandom_range(0, lim < 16 ? lim - 1 : 15);
        else if (r < 8) d = $urandom_range(0, lim - 1);
        else d = lim - 1;
        add_copy(d, $urandom_range(0, 2) == 0 ? 15 : $urandom_range(1, 15));
      end
    end
  endtask

  task automatic test_ending();
    ending     = end_kind_t'($urandom_range(0, 5));
    size_field = plan_len;
    case (ending)
      END_SIZE_LOW:  size_field = plan_len - $urandom_range(1, plan_len - 1);
      END_SIZE_HIGH: begin
        if ($urandom_range(0, 1) == 0) size_field = 32'hFFFF_FFFF;
        else size_field = plan_len + $urandom_range(1, 1000);
      end
      default: ;
    endcase
    if (ending == END_BAD_DIST) add_copy($urandom_range(plan_len, HIST_DEPTH - 1),
                                         $urandom_range(1, 15));
    else add_copy($urandom_range(0, HIST_DEPTH - 1), 0);
    pack_commands();
    if (ending == END_OK_FIN) body_q[body_q.size()-1].fin = 1'b1;
    if (ending == END_EARLY) body_q[$urandom_range(0, body_q.size() - 2)].fin = 1'b1;
  endtask

  task automatic test_header();
    logic [63:0] hdr;
    int unsigned pos;
    hdr_kind = HDR_GOOD;
    if ($urandom_range(0, 7) == 0) hdr_kind = hdr_kind_t'($urandom_range(1, 3));
    hdr = {(hdr_kind == HDR_ZERO_SIZE) ? 32'h0 : size_field, ID_WORD};
    pos = $urandom_range(0, 7);
    if (hdr_kind == HDR_BAD_ID) hdr[$urandom_range(0, 31)] ^= 1'b1;
    for (int i = 0; i < 8; i++)
      stream_q = {stream_q,
                  plan_beat_t'({hdr[8*i +: 8], hdr_kind == HDR_EARLY && i == pos})};
    foreach (body_q[i]) stream_q = {stream_q, body_q[i]};
  endtask

  task automatic test_send_stream();
    foreach (stream_q[i]) begin
      if (i >= stream_q.size() * 85 / 100) calm = 1'b1;
      send_beat(stream_q[i].data, stream_q[i].fin);
    end
  endtask

  task automatic test_ignored_tail();
    for (int i = 0; i < 12; i++) send_beat(byte_t'($urandom), $urandom_range(0, 1));
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_commands();
    test_random_commands();
    test_ending();
    test_header();
    test_send_stream();
    test_ignored_tail();
    for (int i = 0; i < 20000 && exp_q.size() != 0; i++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (exp_q.size() != 0) report_mismatch("beats never delivered", exp_q.size(), 0);
    $display("run: %0d beats in, %0d beats out, %0d bytes decoded by the model",
             n_in, n_out, out_count);
    $display("run: header %0s, stream ending %0s, %0d mismatches",
             hdr_kind.name(), ending.name(), n_err);
    if (n_err == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    #16_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
